// ===== sv/pipr_pkg.sv =====
// ----------------------------------------------------------------------------
// pipr_pkg
// shared types, constants and helper functions of the paletted resampler
// ----------------------------------------------------------------------------
`default_nettype none

package pipr_pkg;

  localparam int DIM_W      = 10;               // source dimension register width
  localparam int POS_W      = 9;                // source row or column index width
  localparam int OUT_DIM_W  = 9;                // output dimension width
  localparam int LG_W       = 4;                // log2 of output dimension
  localparam int MAX_OUT_LG = 8;                // output dimension cap is 2**8
  localparam int PAL_AW     = 8;
  localparam int PAL_DEPTH  = 1 << PAL_AW;
  localparam int SRC_AW     = 18;
  localparam int SRC_DEPTH  = 1 << SRC_AW;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int ACC_W      = CH_W + 2;         // sum of four channel values
  localparam int PROD_W     = 2 * DIM_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_W-1:0] MAX_IN_DIM = DIM_W'(512);
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

  // action codes on the input channel
  localparam logic [1:0] ACT_PAL   = 2'd0;
  localparam logic [1:0] ACT_SRC   = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;

  // configuration register indexes
  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_IN_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    K_PAL,
    K_SRC,
    K_FETCH,
    K_ERR,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ODD,
    F_BASE1,
    F_BASE2
  } front_state_t;

  typedef struct packed {
    kind_t                kind;
    logic [SRC_AW-1:0]    address;
    logic [COLOR_W-1:0]   data;
    logic [POS_W-1:0]     c1;
    logic [POS_W-1:0]     c2;
    logic [SRC_AW-1:0]    base1;
    logic [SRC_AW-1:0]    base2;
  } entry_t;

  typedef struct packed {
    logic [OUT_DIM_W-1:0] out_w;
    logic [OUT_DIM_W-1:0] out_h;
  } dims_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    if (v > MAX_IN_DIM) r = MAX_IN_DIM;
    return r;
  endfunction

  // log2 of the smallest power of two not below n, capped
  function automatic logic [LG_W-1:0] pow2_log(input logic [DIM_W-1:0] n);
    logic [LG_W-1:0] lg;
    lg = LG_W'(MAX_OUT_LG);
    for (int k = MAX_OUT_LG - 1; k >= 0; k--) begin
      if (n <= (DIM_W'(1) << k)) lg = LG_W'(k);
    end
    return lg;
  endfunction

endpackage

`default_nettype wire

// ===== sv/palette_image_pow2_resample_unit.sv =====
// ----------------------------------------------------------------------------
// palette_image_pow2_resample_unit
// paletted image store with power-of-two 2x2 averaged per-pixel fetch
// ----------------------------------------------------------------------------
// path: a write goes from the queue through the source read, palette read and
//   result registers; a fetch first steps the front through F_ODD, F_BASE1, F_BASE2
// throughput, unless the queue is full or output is held: one write per cycle;
//   a fetch holds the front through its multiplier steps (two positions, two
//   row bases); the single source read port takes its four taps one per cycle
// reset: clears control state and sets in_width and in_height to 1; the
//   palette and source stores are not cleared and hold garbage until written
`default_nettype none

module palette_image_pow2_resample_unit
  import pipr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  // input item channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           action,
  input  wire logic [SRC_AW-1:0]    address,
  input  wire logic [COLOR_W-1:0]   data,
  input  wire logic [CH_W-1:0]      out_x,
  input  wire logic [CH_W-1:0]      out_y,
  // result item channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CH_W-1:0]           red,
  output logic [CH_W-1:0]           green,
  output logic [CH_W-1:0]           blue,
  output logic [CH_W-1:0]           alpha,
  output logic [OUT_DIM_W-1:0]      out_width,
  output logic [OUT_DIM_W-1:0]      out_height,
  output logic                      status
);

  // front to queue
  logic   q_push;
  logic   q_full;
  entry_t push_entry;
  // queue to back
  logic   q_pop;
  logic   q_valid;
  entry_t head_entry;
  // current output size; the user keeps it stable while items are in flight, not enforced
  dims_t  dims;

  // front: config, accept, classify, sample positions and row bases
  pipr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .address    (address),
    .data       (data),
    .out_x      (out_x),
    .out_y      (out_y),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry),
    .dims       (dims)
  );

  // decoupling queue, two items deep
  pipr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  // back: memory writes, tap reads, palette lookup, averaging
  pipr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .dims       (dims),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .out_width  (out_width),
    .out_height (out_height),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== sv/pipr_queue.sv =====
// ----------------------------------------------------------------------------
// pipr_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_queue
  import pipr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        head_valid,
  output entry_t      head_entry
);

  entry_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pipr_front.sv =====
// ----------------------------------------------------------------------------
// pipr_front
// config registers, item accept, classification and sample address math
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_front
  import pipr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           action,
  input  wire logic [SRC_AW-1:0]    address,
  input  wire logic [COLOR_W-1:0]   data,
  input  wire logic [CH_W-1:0]      out_x,
  input  wire logic [CH_W-1:0]      out_y,
  input  wire logic                 q_full,
  output logic                      q_push,
  output entry_t                    q_entry,
  output dims_t                     dims
);

  front_state_t       state, state_next;
  logic [DIM_W-1:0]   in_width, in_height;
  logic [LG_W-1:0]    lg_w, lg_h;
  logic [CH_W-1:0]    ox, oy;
  logic [POS_W-1:0]   c1, c2, r1, r2;
  logic [SRC_AW-1:0]  base1;
  logic [DIM_W-1:0]   xa, ya, yb;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic [POS_W-1:0]   pos_x, pos_y;
  logic               accept, outside;
  kind_t              kind_in;

  assign dims = '{out_w: OUT_DIM_W'(1) << lg_w, out_h: OUT_DIM_W'(1) << lg_h};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= DIM_W'(1);
      in_height <= DIM_W'(1);
      lg_w      <= '0;
      lg_h      <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_IN_WIDTH) begin
        in_width <= clamp_dim(cfg_data);
        lg_w     <= pow2_log(clamp_dim(cfg_data));
      end else begin
        in_height <= clamp_dim(cfg_data);
        lg_h      <= pow2_log(clamp_dim(cfg_data));
      end
    end
  end

  assign accept  = in_valid && !in_stall;
  assign outside = ({1'b0, out_x} >= dims.out_w) || ({1'b0, out_y} >= dims.out_h);

  always_comb begin
    unique case (action)
      ACT_PAL:   kind_in = K_PAL;
      ACT_SRC:   kind_in = K_SRC;
      ACT_FETCH: kind_in = outside ? K_ERR : K_FETCH;
      default:   kind_in = K_NOP;
    endcase
  end

  // two multipliers: column and row positions, then row times width
  always_comb begin
    xa = {out_x, 2'b01};
    ya = {out_y, 2'b01};
    yb = in_height;
    case (state)
      F_ODD: begin
        xa = {ox, 2'b11};
        ya = {oy, 2'b11};
      end
      F_BASE1: begin
        ya = {1'b0, r1};
        yb = in_width;
      end
      F_BASE2: begin
        ya = {1'b0, r2};
        yb = in_width;
      end
      default: ;
    endcase
  end

  assign prod_x = PROD_W'(xa) * PROD_W'(in_width);
  assign prod_y = PROD_W'(ya) * PROD_W'(yb);
  assign pos_x  = POS_W'(prod_x >> (lg_w + LG_W'(2)));
  assign pos_y  = POS_W'(prod_y >> (lg_h + LG_W'(2)));

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (accept && kind_in == K_FETCH) state_next = F_ODD;
      F_ODD:   state_next = F_BASE1;
      F_BASE1: state_next = F_BASE2;
      F_BASE2: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    q_entry  = '{kind: kind_in, address: address, data: data,
                 c1: c1, c2: c2, base1: base1, base2: prod_y[SRC_AW-1:0]};
    unique case (state)
      F_IDLE: begin
        in_stall = q_full;
        q_push   = accept && (kind_in != K_FETCH);
      end
      F_BASE2: begin
        q_entry.kind = K_FETCH;
        q_push       = !q_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      ox <= out_x;
      oy <= out_y;
      c1 <= pos_x;
      r1 <= pos_y;
    end
    if (state == F_ODD) begin
      c2 <= pos_x;
      r2 <= pos_y;
    end
    if (state == F_BASE1) base1 <= prod_y[SRC_AW-1:0];
  end

endmodule

`default_nettype wire

// ===== sv/pipr_back.sv =====
// ----------------------------------------------------------------------------
// pipr_back
// memory writes, four-tap source and palette reads, averaging, result register
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_back
  import pipr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire entry_t               q_entry,
  output logic                      q_pop,
  input  wire dims_t                dims,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CH_W-1:0]           red,
  output logic [CH_W-1:0]           green,
  output logic [CH_W-1:0]           blue,
  output logic [CH_W-1:0]           alpha,
  output logic [OUT_DIM_W-1:0]      out_width,
  output logic [OUT_DIM_W-1:0]      out_height,
  output logic                      status
);

  logic [CH_W-1:0]    src_mem [SRC_DEPTH];
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];

  logic               en, issue, is_fetch, last_tap;
  logic [1:0]         sub;
  logic [SRC_AW-1:0]  rd_addr;
  logic [CH_W-1:0]    src_q;
  logic [COLOR_W-1:0] pal_q;
  logic               s1_valid, s1_first, s1_last;
  logic               s2_valid, s2_first, s2_last;
  kind_t              s1_kind, s2_kind;
  logic [ACC_W-1:0]   acc_r, acc_g, acc_b;
  logic [ACC_W-1:0]   sum_r, sum_g, sum_b;

  // whole pipeline freezes while the result register is held
  assign en       = !out_valid || !out_stall;
  assign issue    = q_valid && en;
  assign is_fetch = (q_entry.kind == K_FETCH);
  assign last_tap = !is_fetch || (sub == 2'd3);
  assign q_pop    = issue && last_tap;

  // taps in order: (r1,c1) (r1,c2) (r2,c1) (r2,c2), index wraps
  assign rd_addr = (sub[1] ? q_entry.base2 : q_entry.base1)
                 + SRC_AW'(sub[0] ? q_entry.c2 : q_entry.c1);

  always_ff @(posedge clk) begin
    if (rst) sub <= '0;
    else if (issue && is_fetch) sub <= sub + 1'b1;
  end

  // source address always fits the store
  always_ff @(posedge clk) begin
    if (issue && q_entry.kind == K_SRC) src_mem[q_entry.address] <= q_entry.data[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) src_q <= src_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (issue && q_entry.kind == K_PAL && q_entry.address[SRC_AW-1:PAL_AW] == '0) begin
      pal_mem[q_entry.address[PAL_AW-1:0]] <= q_entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) pal_q <= pal_mem[src_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind  <= q_entry.kind;
      s1_first <= (sub == 2'd0);
      s1_last  <= last_tap;
      s2_kind  <= s1_kind;
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
  end

  assign sum_r = (s2_first ? '0 : acc_r) + ACC_W'(pal_q[23:16]);
  assign sum_g = (s2_first ? '0 : acc_g) + ACC_W'(pal_q[15:8]);
  assign sum_b = (s2_first ? '0 : acc_b) + ACC_W'(pal_q[7:0]);

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      acc_r <= sum_r;
      acc_g <= sum_g;
      acc_b <= sum_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s2_valid && s2_last;
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid && s2_last) begin
      out_width  <= dims.out_w;
      out_height <= dims.out_h;
      red    <= '0;
      green  <= '0;
      blue   <= '0;
      alpha  <= '0;
      status <= 1'b0;
      case (s2_kind)
        K_FETCH: begin
          red   <= sum_r[ACC_W-1:2];
          green <= sum_g[ACC_W-1:2];
          blue  <= sum_b[ACC_W-1:2];
          alpha <= ALPHA_OPAQUE;
        end
        K_ERR:   status <= 1'b1;
        default: ;
      endcase
    end
  end

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(s2_valid) && $stable(sub) && $stable(s1_valid)))
    else $error("pipeline moved while result held");

  a_head_fetch: assert property (@(posedge clk) disable iff (rst)
    (sub != 2'd0) |-> (q_valid && q_entry.kind == K_FETCH))
    else $error("tap counter busy without a fetch at queue head");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (en && s2_valid && s2_last) |=> out_valid)
    else $error("finished item did not reach result register");

  a_first_tap: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && s1_first) |=> (s2_valid && s2_first))
    else $error("first tap lost between read stages");

endmodule

`default_nettype wire
